FILE: src/incremental_pid_controller_core_macros.svh
// Assertion macros shared by the PID controller RTL.
// Simulation gets concurrent assertions; synthesis sees empty bodies.
`ifndef INCREMENTAL_PID_CONTROLLER_CORE_MACROS_SVH
`define INCREMENTAL_PID_CONTROLLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define PIDC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pidc: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define PIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pidc: next-cycle check failed");
`else
`define PIDC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/pidc_pkg.sv
// Types and constants for the incremental PID controller.
// No dependencies; used by every module of the block.
package pidc_pkg;

	localparam int DATA_W  = 16;
	localparam int GAIN_W  = 16;
	localparam int ERR_W   = 17;
	localparam int DIFF1_W = 18;
	localparam int DIFF2_W = 19;
	localparam int PROD_W  = 35;
	localparam int SUM_W   = 37;
	localparam int ACC_W   = 32;
	localparam int FRAC_W  = 8;
	localparam int ADDR_W  = 2;

	localparam logic [ADDR_W-1:0] REG_GAIN_P = 2'd0;
	localparam logic [ADDR_W-1:0] REG_GAIN_I = 2'd1;
	localparam logic [ADDR_W-1:0] REG_GAIN_D = 2'd2;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef enum logic {
		OP_COMPUTE = 1'b0,
		OP_CLEAR   = 1'b1
	} op_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] p;
		logic signed [GAIN_W-1:0] i;
		logic signed [GAIN_W-1:0] d;
	} gains_t;

	typedef struct packed {
		op_t                     op;
		logic signed [ERR_W-1:0] err;
	} err_item_t;

	typedef struct packed {
		op_t                      op;
		logic signed [PROD_W-1:0] term_p;
		logic signed [PROD_W-1:0] term_i;
		logic signed [PROD_W-1:0] term_d;
	} term_item_t;

endpackage

FILE: src/pidc_err_stage.sv
// Input register of the PID controller: captures a request and forms the error.
// Depends on pidc_pkg.
module pidc_err_stage (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic signed [pidc_pkg::DATA_W-1:0]   measured,
	input  logic signed [pidc_pkg::DATA_W-1:0]   target,
	output logic                                 err_valid,
	input  logic                                 err_ready,
	output pidc_pkg::err_item_t                  err_item
);

	logic                valid_s1;
	pidc_pkg::err_item_t item_s1;
	logic                load;

	assign in_ready = !valid_s1 || err_ready;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// The difference of two 16-bit values always fits in 17 bits.
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.op  <= pidc_pkg::op_t'(op);
			item_s1.err <= $signed({target[pidc_pkg::DATA_W-1], target})
				- $signed({measured[pidc_pkg::DATA_W-1], measured});
		end
	end

	assign err_valid = valid_s1;
	assign err_item  = item_s1;

endmodule

FILE: src/pidc_term_stage.sv
// Product stage: keeps the error history and forms the three gain products.
// Depends on pidc_pkg and the assertion macro header.
`include "incremental_pid_controller_core_macros.svh"
module pidc_term_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  pidc_pkg::gains_t    gains,
	input  logic                err_valid,
	output logic                err_ready,
	input  pidc_pkg::err_item_t err_item,
	output logic                term_valid,
	input  logic                term_ready,
	output pidc_pkg::term_item_t term_item
);

	localparam int EW = pidc_pkg::ERR_W;
	localparam int GW = pidc_pkg::GAIN_W;
	localparam int D1 = pidc_pkg::DIFF1_W;
	localparam int D2 = pidc_pkg::DIFF2_W;
	localparam int PW = pidc_pkg::PROD_W;

	logic                     valid_s2;
	pidc_pkg::term_item_t     item_s2;
	logic signed [EW-1:0]     err_last_q;
	logic signed [EW-1:0]     err_prev_q;
	logic                     load;
	logic signed [D1-1:0]     diff1;
	logic signed [D2-1:0]     diff2;
	logic signed [D2-1:0]     e0_x;
	logic signed [D2-1:0]     e1_x;
	logic signed [D2-1:0]     e2_x;
	logic signed [PW-1:0]     prod_p;
	logic signed [PW-1:0]     prod_i;
	logic signed [PW-1:0]     prod_d;

	assign err_ready = !valid_s2 || term_ready;
	assign load      = err_valid && err_ready;

	always_comb begin
		e0_x  = {{(D2-EW){err_item.err[EW-1]}}, err_item.err};
		e1_x  = {{(D2-EW){err_last_q[EW-1]}}, err_last_q};
		e2_x  = {{(D2-EW){err_prev_q[EW-1]}}, err_prev_q};
		diff1 = e0_x[D1-1:0] - e1_x[D1-1:0];
		diff2 = e0_x - (e1_x <<< 1) + e2_x;
		// Operands are widened to the product width so that each multiply is exact.
		prod_p = $signed({{(PW-GW){gains.p[GW-1]}}, gains.p})
			* $signed({{(PW-D1){diff1[D1-1]}}, diff1});
		prod_i = $signed({{(PW-GW){gains.i[GW-1]}}, gains.i})
			* $signed({{(PW-EW){err_item.err[EW-1]}}, err_item.err});
		prod_d = $signed({{(PW-GW){gains.d[GW-1]}}, gains.d})
			* $signed({{(PW-D2){diff2[D2-1]}}, diff2});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			err_last_q <= '0;
			err_prev_q <= '0;
		end else begin
			if (err_ready) begin
				valid_s2 <= err_valid;
			end
			if (load) begin
				if (err_item.op == pidc_pkg::OP_CLEAR) begin
					err_last_q <= '0;
					err_prev_q <= '0;
				end else begin
					err_prev_q <= err_last_q;
					err_last_q <= err_item.err;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2.op     <= err_item.op;
			item_s2.term_p <= prod_p;
			item_s2.term_i <= prod_i;
			item_s2.term_d <= prod_d;
		end
	end

	assign term_valid = valid_s2;
	assign term_item  = item_s2;

	`PIDC_ASSERT_NEXT(a_clear_history, clk, arst_n, load && (err_item.op == pidc_pkg::OP_CLEAR), (err_last_q == '0) && (err_prev_q == '0))
	`PIDC_ASSERT_NEXT(a_history_shift, clk, arst_n, load && (err_item.op == pidc_pkg::OP_COMPUTE), err_prev_q == $past(err_last_q))

endmodule

FILE: src/pidc_acc_stage.sv
// Result stage: sums the products, scales by 1/256 toward zero and accumulates
// with saturation into the output register. Depends on pidc_pkg and the macro header.
`include "incremental_pid_controller_core_macros.svh"
module pidc_acc_stage (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                term_valid,
	output logic                                term_ready,
	input  pidc_pkg::term_item_t                term_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pidc_pkg::ACC_W-1:0]   control_out,
	output logic                                saturated
);

	localparam int PW = pidc_pkg::PROD_W;
	localparam int SW = pidc_pkg::SUM_W;
	localparam int AW = pidc_pkg::ACC_W;
	localparam int FW = pidc_pkg::FRAC_W;

	logic                 valid_q;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] result_q;
	logic                 sat_q;
	logic                 load;
	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] biased;
	logic signed [AW-1:0] delta;
	logic signed [AW:0]   acc_wide;
	logic signed [AW-1:0] acc_next;
	logic                 sat_next;

	assign term_ready = !valid_q || out_ready;
	assign load       = term_valid && term_ready;

	always_comb begin
		sum = $signed({{(SW-PW){term_item.term_p[PW-1]}}, term_item.term_p})
			+ $signed({{(SW-PW){term_item.term_i[PW-1]}}, term_item.term_i})
			+ $signed({{(SW-PW){term_item.term_d[PW-1]}}, term_item.term_d});
		// Adding 255 to a negative sum before the shift makes it truncate toward zero.
		biased = sum + (sum[SW-1] ? SW'((1 << FW) - 1) : SW'(0));
		delta  = {{(AW-(SW-FW)){biased[SW-1]}}, biased[SW-1:FW]};
		acc_wide = $signed({acc_q[AW-1], acc_q}) + $signed({delta[AW-1], delta});
		if (acc_wide[AW] != acc_wide[AW-1]) begin
			sat_next = 1'b1;
			acc_next = acc_wide[AW] ? pidc_pkg::ACC_MIN : pidc_pkg::ACC_MAX;
		end else begin
			sat_next = 1'b0;
			acc_next = acc_wide[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			acc_q   <= '0;
		end else begin
			if (term_ready) begin
				valid_q <= term_valid;
			end
			if (load && (term_item.op == pidc_pkg::OP_COMPUTE)) begin
				acc_q <= acc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (term_item.op == pidc_pkg::OP_CLEAR) begin
				result_q <= '0;
				sat_q    <= 1'b0;
			end else begin
				result_q <= acc_next;
				sat_q    <= sat_next;
			end
		end
	end

	assign out_valid   = valid_q;
	assign control_out = result_q;
	assign saturated   = sat_q;

	`PIDC_ASSERT_SAME(a_sat_at_limit, clk, arst_n, out_valid && saturated, (control_out == pidc_pkg::ACC_MAX) || (control_out == pidc_pkg::ACC_MIN))
	`PIDC_ASSERT_NEXT(a_clear_keeps_acc, clk, arst_n, load && (term_item.op == pidc_pkg::OP_CLEAR), (acc_q == $past(acc_q)) && (control_out == '0) && !saturated)
	`PIDC_ASSERT_NEXT(a_result_is_acc, clk, arst_n, load && (term_item.op == pidc_pkg::OP_COMPUTE), control_out == acc_q)

endmodule

FILE: src/incremental_pid_controller_core.sv
// Top level of the incremental (velocity-form) PID controller core.
// Depends on pidc_pkg, pidc_err_stage, pidc_term_stage and pidc_acc_stage.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    op, measured, target
//   output    out_valid / out_ready  control_out, saturated
//   config    cfg_wr_en              cfg_addr, cfg_wdata (gain_p, gain_i, gain_d)
//
// One request is taken per cycle unless a stall has filled the stages; each passes three registers.
// The accumulator in the result stage is a register fed back through its adder and saturator.
// Reset clears the gains, the error history and the accumulator; the output register is not reset.
// A stalled output holds each stage in turn; ready propagates back through the three stages.
module incremental_pid_controller_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [pidc_pkg::ADDR_W-1:0]          cfg_addr,
	input  logic [pidc_pkg::GAIN_W-1:0]          cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic signed [pidc_pkg::DATA_W-1:0]   measured,
	input  logic signed [pidc_pkg::DATA_W-1:0]   target,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [pidc_pkg::ACC_W-1:0]    control_out,
	output logic                                 saturated
);

	pidc_pkg::gains_t     gains_q;
	logic                 err_valid;
	logic                 err_ready;
	pidc_pkg::err_item_t  err_item;
	logic                 term_valid;
	logic                 term_ready;
	pidc_pkg::term_item_t term_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				pidc_pkg::REG_GAIN_P: gains_q.p <= $signed(cfg_wdata);
				pidc_pkg::REG_GAIN_I: gains_q.i <= $signed(cfg_wdata);
				pidc_pkg::REG_GAIN_D: gains_q.d <= $signed(cfg_wdata);
				default: gains_q <= gains_q;
			endcase
		end
	end

	pidc_err_stage u_err (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.measured  (measured),
		.target    (target),
		.err_valid (err_valid),
		.err_ready (err_ready),
		.err_item  (err_item)
	);

	pidc_term_stage u_term (
		.clk        (clk),
		.arst_n     (arst_n),
		.gains      (gains_q),
		.err_valid  (err_valid),
		.err_ready  (err_ready),
		.err_item   (err_item),
		.term_valid (term_valid),
		.term_ready (term_ready),
		.term_item  (term_item)
	);

	pidc_acc_stage u_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.term_valid  (term_valid),
		.term_ready  (term_ready),
		.term_item   (term_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.control_out (control_out),
		.saturated   (saturated)
	);

endmodule
